@@ hw/rtl/mhpq_pkg.sv @@
// Package for the max-heap priority queue: operation and status codes,
// default sizes and the result record passed from the sequencer to the top.
// No dependencies.
package mhpq_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 11;
    localparam int STAT_W  = 2;
    localparam int OUT_W   = 48;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [OCC_W-1:0]          occupancy;
    } result_t;

endpackage

@@ hw/rtl/mhpq_ram.sv @@
// Key store of the heap: one write port and one read port, registered read.
// Depends on nothing.
module mhpq_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/mhpq_ctrl.sv @@
// Sequencer of the heap: walks sift-up and sift-down one level at a time
// through the key store, using one shared signed comparator.
// Depends on mhpq_pkg and drives the ports of mhpq_ram.
module mhpq_ctrl #(
    parameter int CAPACITY  = mhpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF,
    parameter int AW        = $clog2(CAPACITY),
    parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_cmd,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] req_value,
    output logic                            res_valid,
    input  logic                            res_ready,
    output mhpq_pkg::result_t               res,
    output logic                            ram_we,
    output logic [AW-1:0]                   ram_waddr,
    output logic [KEY_WIDTH-1:0]            ram_wdata,
    output logic [AW-1:0]                   ram_raddr,
    input  logic [KEY_WIDTH-1:0]            ram_rdata
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_RD   = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_RM_ROOT = 4'd3;
    localparam logic [3:0] S_RM_LAST = 4'd4;
    localparam logic [3:0] S_DN_L    = 4'd5;
    localparam logic [3:0] S_DN_LD   = 4'd6;
    localparam logic [3:0] S_DN_RD   = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]                         state_reg, state_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [AW-1:0]                      pos_reg, pos_next;
    logic [AW-1:0]                      pick_reg, pick_next;
    logic [KEY_WIDTH-1:0]               key_reg, key_next;
    logic [KEY_WIDTH-1:0]               child_reg, child_next;
    logic [mhpq_pkg::STAT_W-1:0]        status_reg, status_next;
    logic signed [mhpq_pkg::VALUE_W-1:0] removed_reg, removed_next;

    logic [KEY_WIDTH-1:0] key_in;
    logic [AW-1:0]        up_idx;
    logic [CNT_W:0]       left_idx, right_idx, count_ext;
    logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
    logic                 cmp_gt;

    // wrap the 32-bit value into the key width, sign-extending when wider
    assign key_in = KEY_WIDTH'(req_value);

    assign up_idx    = (pos_reg - AW'(1)) >> 1;
    assign left_idx  = (CNT_W + 1)'({pos_reg, 1'b1});
    assign right_idx = left_idx + (CNT_W + 1)'(1);
    assign count_ext = (CNT_W + 1)'(count_reg);

    // shared comparator: operands chosen by the sequencer state
    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = key_reg;
                cmp_b = ram_rdata;
            end
            S_DN_RD:
            begin
                cmp_a = ram_rdata;
                cmp_b = child_reg;
            end
            default:
            begin
                cmp_a = child_reg;
                cmp_b = key_reg;
            end
        endcase
    end

    assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status        = status_reg;
    assign res.removed_value = removed_reg;
    assign res.occupancy     = mhpq_pkg::OCC_W'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        pick_next    = pick_reg;
        key_next     = key_reg;
        child_next   = child_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = key_reg;
        ram_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next  = mhpq_pkg::ST_OK;
                    removed_next = '1;
                    if (req_cmd == mhpq_pkg::CMD_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = mhpq_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            key_next   = key_in;
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CNT_W'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mhpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_RM_ROOT;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = up_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    // parent moves down, key climbs one level
                    ram_wdata  = ram_rdata;
                    pos_next   = up_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RM_ROOT:
            begin
                removed_next = mhpq_pkg::VALUE_W'($signed(ram_rdata));
                ram_raddr    = count_reg[AW-1:0];
                state_next   = (count_reg == '0) ? S_DONE : S_RM_LAST;
            end
            S_RM_LAST:
            begin
                key_next   = ram_rdata;
                pos_next   = '0;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (left_idx >= count_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = left_idx[AW-1:0];
                    state_next = S_DN_LD;
                end
            end
            S_DN_LD:
            begin
                child_next = ram_rdata;
                pick_next  = left_idx[AW-1:0];
                if (right_idx < count_ext)
                begin
                    ram_raddr  = right_idx[AW-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_RD:
            begin
                // right child wins only when strictly larger
                if (cmp_gt)
                begin
                    child_next = ram_rdata;
                    pick_next  = right_idx[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    ram_wdata  = child_reg;
                    pos_next   = pick_reg;
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        pick_reg    <= pick_next;
        key_reg     <= key_next;
        child_reg   <= child_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

endmodule

@@ hw/rtl/max_heap_priority_queue.sv @@
// Binary max-heap priority queue: top level with the request channel,
// result register, key store and sequencer.
// Depends on mhpq_pkg, mhpq_ram and mhpq_ctrl.
//
// Usage:
//   One request per operation: s_axis_tuser picks insert (0) or remove
//   maximum (1), s_axis_tdata holds the signed key (ignored on a remove).
//   Each request gives one result: m_axis_tuser is the status (ok, remove
//   from empty heap, insert into full heap dropped), m_axis_tdata the removed
//   key (-1 on insert or empty) and the number of keys held afterwards.
// Sequencing:
//   The sequencer reads the key store through one registered read port and
//   settles each level with the shared comparator: an insert reads the parent
//   and compares for each level climbed; a remove reads the root and the last
//   key, then for each level descended reads the children and compares. Full
//   and empty requests go straight to the result. The result passes through
//   the output register to m_axis, and s_axis_tready rises in the same cycle as m_axis_tvalid.
// Reset and stalls:
//   Reset empties the heap and the result register; store contents are not
//   cleared. A stalled receiver keeps its result in the output register while
//   the sequencer takes the next request and holds that result until it frees.
module max_heap_priority_queue #(
    parameter int CAPACITY  = mhpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] removed_value, [42:32] occupancy, rest 0
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic                 res_valid;
    logic                 res_ready;
    mhpq_pkg::result_t    res;

    logic                 out_valid_reg, out_valid_next;
    mhpq_pkg::result_t    out_res_reg;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (KEY_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mhpq_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .AW        (AW),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_cmd   (s_axis_tuser),
        .req_value ($signed(s_axis_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // load the output register whenever it is empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {5'd0, out_res_reg.occupancy, out_res_reg.removed_value};

endmodule
